>>> rtl/windowed_energy_threshold_detector_assert.svh
// Assertion macros shared by the energy detector RTL.
// Needs nothing else; files that check their logic include it by name.
`ifndef WINDOWED_ENERGY_THRESHOLD_DETECTOR_ASSERT_SVH
`define WINDOWED_ENERGY_THRESHOLD_DETECTOR_ASSERT_SVH
`ifndef SYNTHESIS
// Checked while the reset is released.
`define WETD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
// Checked at every clock edge, reset included.
`define WETD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error(msg);
`else
`define WETD_ASSERT(lbl, clk, rst_n, prop, msg)
`define WETD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/wetd_pkg.sv
// Package of the windowed energy threshold detector: sizes, constants and types.
// Used by the interfaces, the output queue and the top level.
`timescale 1ns / 1ps

package wetd_pkg;

    localparam int NUM_CHANNELS = 20;
    localparam int WINDOW       = 100;
    localparam int SAMPLE_BITS  = 16;

    // Fixed field widths of the channels and the register.
    localparam int CH_W     = 5;
    localparam int SAMPLE_W = 16;
    localparam int ENERGY_W = 37;

    localparam logic [ENERGY_W-1:0] THRESHOLD_RESET = 37'd500;

    localparam int POS_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int ST_AW      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int RING_DEPTH = NUM_CHANNELS * WINDOW;
    localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SQ_W       = 2 * SAMPLE_BITS - 1;

    // Per-channel state word kept in the state RAM.
    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic                rec;
        logic                wrapped;
        logic [POS_W-1:0]    pos;
    } chan_state_t;

    typedef struct packed {
        logic [CH_W-1:0]     channel_out;
        logic [ENERGY_W-1:0] energy;
        logic                above_threshold;
        logic                new_detection;
        logic                recording_flag;
    } result_t;

endpackage

>>> rtl/wetd_ifs.sv
// Valid/ready channel interfaces of the energy detector (samples in, results out).
// Depends on wetd_pkg for the field widths.
`timescale 1ns / 1ps

interface wetd_sample_if;
    logic                                valid;
    logic                                ready;
    logic [wetd_pkg::CH_W-1:0]           channel;
    logic signed [wetd_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface wetd_result_if;
    logic                          valid;
    logic                          ready;
    logic [wetd_pkg::CH_W-1:0]     channel_out;
    logic [wetd_pkg::ENERGY_W-1:0] energy;
    logic                          above_threshold;
    logic                          new_detection;
    logic                          recording_flag;

    modport source (output valid, output channel_out, output energy,
                    output above_threshold, output new_detection,
                    output recording_flag, input ready);
    modport sink   (input valid, input channel_out, input energy,
                    input above_threshold, input new_detection,
                    input recording_flag, output ready);
endinterface

>>> rtl/wetd_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Read-first: a read and a write of the same address return the old word.
`timescale 1ns / 1ps

module wetd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/wetd_outq.sv
// Two-entry result queue that decouples the detector pipeline from the consumer.
// Depends on wetd_pkg and the result interface; includes the assertion macros.
`timescale 1ns / 1ps
`include "windowed_energy_threshold_detector_assert.svh"

module wetd_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  wetd_pkg::result_t item,
    output logic              room,
    wetd_result_if.source     results
);

    wetd_pkg::result_t slot_reg [2];
    wetd_pkg::result_t head;
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        cnt_reg;
    logic [1:0]        cnt_next;
    logic              pop;

    assign pop  = results.valid && results.ready;
    assign room = (cnt_reg != 2'd2);

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

    assign head                    = slot_reg[rd_ptr_reg];
    assign results.valid           = (cnt_reg != 2'd0);
    assign results.channel_out     = head.channel_out;
    assign results.energy          = head.energy;
    assign results.above_threshold = head.above_threshold;
    assign results.new_detection   = head.new_detection;
    assign results.recording_flag  = head.recording_flag;

    `WETD_ASSERT(a_no_overflow, clk, rst_n, push |-> room, "result pushed into a full queue")
    `WETD_ASSERT(a_ptr_empty, clk, rst_n,
        (cnt_reg == 2'd0) |-> (wr_ptr_reg == rd_ptr_reg),
        "queue pointers disagree while empty")
    `WETD_ASSERT_ALWAYS(a_cnt_range, clk, (!rst_n) || (cnt_reg != 2'd3),
        "queue count out of range")

endmodule

>>> rtl/windowed_energy_threshold_detector.sv
// Top level of the multi-channel sliding-window energy detector.
// Depends on wetd_pkg, wetd_ifs, wetd_ram and wetd_outq; includes the assertion macros.
//
//   Channel   Direction  Handshake      Carries
//   samples   in         valid/ready    channel, sample
//   results   out        valid/ready    channel_out, energy, above_threshold,
//                                       new_detection, recording_flag
//   cfg_wr    in         write enable   threshold
//
// One request is taken per clock while the output queue has room; its result moves down the
// pipeline registers to the last stage, which pushes it into the queue, where it is registered.
// The per-channel read-modify-write through the state RAM closes at the last stage, with
// forwarding to the younger stages, so one channel may repeat every clock that ready is high.
// Reset clears the state entry valid bits; ring slots count as zero until the channel
// has wrapped once, so no clearing pass runs and requests are taken right after reset.
// Ready drops only while two results wait in the output queue.
`timescale 1ns / 1ps
`include "windowed_energy_threshold_detector_assert.svh"

module windowed_energy_threshold_detector (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [wetd_pkg::ENERGY_W-1:0] cfg_wr_data,
    wetd_sample_if.sink                   samples,
    wetd_result_if.source                 results
);

    localparam int W_ST = $bits(wetd_pkg::chan_state_t);

    logic en;
    logic room;

    logic [wetd_pkg::ENERGY_W-1:0]     threshold_reg;
    logic [wetd_pkg::NUM_CHANNELS-1:0] st_vld_reg;

    // State RAM ports.
    logic [W_ST-1:0]             st_rdata;
    wetd_pkg::chan_state_t       st_rd;
    logic                        st_we;
    wetd_pkg::chan_state_t       st_wdata;

    // Sample ring ports.
    logic                                ring_we;
    logic [wetd_pkg::RING_AW-1:0]        ring_addr;
    logic [wetd_pkg::SAMPLE_BITS-1:0]    ring_rdata;

    logic ch0_ok;

    // Stage 1: state word arriving from the RAM.
    logic                              s1_vld_reg;
    logic [wetd_pkg::CH_W-1:0]         s1_ch_reg;
    logic [wetd_pkg::SAMPLE_BITS-1:0]  s1_smp_reg;
    logic                              s1_stv_reg;
    logic                              s1_byp_reg;
    wetd_pkg::chan_state_t             s1_byp_st_reg;
    wetd_pkg::chan_state_t             base1;
    logic                              s1_ok;
    logic                              s1_live;
    logic [wetd_pkg::POS_W-1:0]        pos1;
    logic                              wrap1;
    logic [wetd_pkg::POS_W-1:0]        pos_next1;
    logic                              wrap_next1;
    logic [wetd_pkg::ENERGY_W-1:0]     e_fwd1;
    logic                              rec_fwd1;
    logic signed [2*wetd_pkg::SAMPLE_BITS-1:0] sq1_full;

    // Stage 2: old sample arriving from the ring.
    logic                              s2_vld_reg;
    logic                              s2_ok_reg;
    logic [wetd_pkg::CH_W-1:0]         s2_ch_reg;
    logic [wetd_pkg::POS_W-1:0]        s2_pos_next_reg;
    logic                              s2_wrap_next_reg;
    logic                              s2_old_ok_reg;
    logic [wetd_pkg::SQ_W-1:0]         s2_newsq_reg;
    logic [wetd_pkg::ENERGY_W-1:0]     s2_e_reg;
    logic                              s2_rec_reg;
    logic                              s2_live;
    logic signed [2*wetd_pkg::SAMPLE_BITS-1:0] sq2_full;
    logic [wetd_pkg::SQ_W-1:0]         oldsq2;
    logic [wetd_pkg::ENERGY_W-1:0]     e_fwd2;
    logic                              rec_fwd2;

    // Stage 3: update, compare and write back.
    logic                              s3_vld_reg;
    logic                              s3_ok_reg;
    logic [wetd_pkg::CH_W-1:0]         s3_ch_reg;
    logic [wetd_pkg::POS_W-1:0]        s3_pos_next_reg;
    logic                              s3_wrap_next_reg;
    logic [wetd_pkg::SQ_W-1:0]         s3_newsq_reg;
    logic [wetd_pkg::SQ_W-1:0]         s3_oldsq_reg;
    logic [wetd_pkg::ENERGY_W-1:0]     s3_e_reg;
    logic                              s3_rec_reg;
    logic                              s3_live;
    logic [wetd_pkg::ENERGY_W-1:0]     e_new3;
    logic                              above3;
    logic                              fresh3;
    logic                              rec_new3;
    logic                              push;
    wetd_pkg::result_t                 res3;

    assign en            = room;
    assign samples.ready = en;
    assign ch0_ok        = int'(samples.channel) < wetd_pkg::NUM_CHANNELS;

    wetd_ram #(
        .WIDTH(W_ST),
        .DEPTH(wetd_pkg::NUM_CHANNELS)
    ) u_state_ram (
        .clk  (clk),
        .re   (en),
        .raddr(wetd_pkg::ST_AW'(samples.channel)),
        .rdata(st_rdata),
        .we   (st_we),
        .waddr(wetd_pkg::ST_AW'(s3_ch_reg)),
        .wdata(st_wdata)
    );

    assign st_rd = wetd_pkg::chan_state_t'(st_rdata);

    wetd_ram #(
        .WIDTH(wetd_pkg::SAMPLE_BITS),
        .DEPTH(wetd_pkg::RING_DEPTH)
    ) u_ring_ram (
        .clk  (clk),
        .re   (en),
        .raddr(ring_addr),
        .rdata(ring_rdata),
        .we   (ring_we),
        .waddr(ring_addr),
        .wdata(s1_smp_reg)
    );

    // Stage 1: resolve the ring position against the two older requests in flight,
    // and pick up the state word that the last stage writes in this cycle.
    always_comb
    begin
        if (s1_byp_reg)
        begin
            base1 = s1_byp_st_reg;
        end
        else if (s1_stv_reg)
        begin
            base1 = st_rd;
        end
        else
        begin
            base1 = '0;
        end

        s1_ok   = int'(s1_ch_reg) < wetd_pkg::NUM_CHANNELS;
        s1_live = s1_vld_reg && s1_ok;

        if (s2_live && (s2_ch_reg == s1_ch_reg))
        begin
            pos1  = s2_pos_next_reg;
            wrap1 = s2_wrap_next_reg;
        end
        else if (s3_live && (s3_ch_reg == s1_ch_reg))
        begin
            pos1  = s3_pos_next_reg;
            wrap1 = s3_wrap_next_reg;
        end
        else
        begin
            pos1  = base1.pos;
            wrap1 = base1.wrapped;
        end

        if (pos1 >= wetd_pkg::POS_W'(wetd_pkg::WINDOW - 1))
        begin
            pos_next1  = '0;
            wrap_next1 = 1'b1;
        end
        else
        begin
            pos_next1  = pos1 + 1'b1;
            wrap_next1 = wrap1;
        end

        if (st_we && (s3_ch_reg == s1_ch_reg))
        begin
            e_fwd1   = st_wdata.energy;
            rec_fwd1 = st_wdata.rec;
        end
        else
        begin
            e_fwd1   = base1.energy;
            rec_fwd1 = base1.rec;
        end
    end

    assign ring_addr = wetd_pkg::RING_AW'(s1_ch_reg) * wetd_pkg::RING_AW'(wetd_pkg::WINDOW)
                     + wetd_pkg::RING_AW'(pos1);
    assign ring_we   = en && s1_live;
    assign sq1_full  = $signed(s1_smp_reg) * $signed(s1_smp_reg);

    // Stage 2: square of the sample leaving the window, and the energy and flag written back by the last stage.
    always_comb
    begin
        s2_live  = s2_vld_reg && s2_ok_reg;
        sq2_full = $signed(ring_rdata) * $signed(ring_rdata);
        oldsq2   = s2_old_ok_reg ? sq2_full[wetd_pkg::SQ_W-1:0] : '0;
        if (st_we && (s3_ch_reg == s2_ch_reg))
        begin
            e_fwd2   = st_wdata.energy;
            rec_fwd2 = st_wdata.rec;
        end
        else
        begin
            e_fwd2   = s2_e_reg;
            rec_fwd2 = s2_rec_reg;
        end
    end

    // Stage 3: the running sum stays exact, so the subtraction never goes negative.
    always_comb
    begin
        s3_live  = s3_vld_reg && s3_ok_reg;
        e_new3   = s3_e_reg - wetd_pkg::ENERGY_W'(s3_oldsq_reg)
                 + wetd_pkg::ENERGY_W'(s3_newsq_reg);
        above3   = e_new3 > threshold_reg;
        fresh3   = above3 && !s3_rec_reg;
        rec_new3 = s3_rec_reg | above3;

        st_wdata.energy  = e_new3;
        st_wdata.rec     = rec_new3;
        st_wdata.wrapped = s3_wrap_next_reg;
        st_wdata.pos     = s3_pos_next_reg;

        res3.channel_out = s3_ch_reg;
        if (s3_ok_reg)
        begin
            res3.energy          = e_new3;
            res3.above_threshold = above3;
            res3.new_detection   = fresh3;
            res3.recording_flag  = rec_new3;
        end
        else
        begin
            res3.energy          = '0;
            res3.above_threshold = 1'b0;
            res3.new_detection   = 1'b0;
            res3.recording_flag  = 1'b0;
        end
    end

    assign st_we = en && s3_live;
    assign push  = en && s3_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            st_vld_reg    <= '0;
            threshold_reg <= wetd_pkg::THRESHOLD_RESET;
        end
        else
        begin
            if (en)
            begin
                s1_vld_reg <= samples.valid;
                s2_vld_reg <= s1_vld_reg;
                s3_vld_reg <= s2_vld_reg;
            end
            if (st_we)
            begin
                st_vld_reg[wetd_pkg::ST_AW'(s3_ch_reg)] <= 1'b1;
            end
            if (cfg_wr_en)
            begin
                threshold_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ch_reg     <= samples.channel;
            s1_smp_reg    <= samples.sample[wetd_pkg::SAMPLE_BITS-1:0];
            s1_stv_reg    <= ch0_ok ? st_vld_reg[wetd_pkg::ST_AW'(samples.channel)] : 1'b0;
            s1_byp_reg    <= st_we && (s3_ch_reg == samples.channel);
            s1_byp_st_reg <= st_wdata;

            s2_ok_reg        <= s1_ok;
            s2_ch_reg        <= s1_ch_reg;
            s2_pos_next_reg  <= pos_next1;
            s2_wrap_next_reg <= wrap_next1;
            s2_old_ok_reg    <= wrap1;
            s2_newsq_reg     <= sq1_full[wetd_pkg::SQ_W-1:0];
            s2_e_reg         <= e_fwd1;
            s2_rec_reg       <= rec_fwd1;

            s3_ok_reg        <= s2_ok_reg;
            s3_ch_reg        <= s2_ch_reg;
            s3_pos_next_reg  <= s2_pos_next_reg;
            s3_wrap_next_reg <= s2_wrap_next_reg;
            s3_newsq_reg     <= s2_newsq_reg;
            s3_oldsq_reg     <= oldsq2;
            s3_e_reg         <= e_fwd2;
            s3_rec_reg       <= rec_fwd2;
        end
    end

    wetd_outq u_outq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (res3),
        .room   (room),
        .results(results)
    );

    `WETD_ASSERT(a_pos_advance, clk, rst_n,
        (st_we && $past(st_we) && (s3_ch_reg == $past(s3_ch_reg)))
        |-> (s3_pos_next_reg ==
             (($past(s3_pos_next_reg) >= wetd_pkg::POS_W'(wetd_pkg::WINDOW - 1))
              ? wetd_pkg::POS_W'(0) : $past(s3_pos_next_reg) + 1'b1)),
        "ring position of back-to-back writes does not advance by one")
    `WETD_ASSERT(a_energy_floor, clk, rst_n,
        st_we |-> (s3_e_reg >= wetd_pkg::ENERGY_W'(s3_oldsq_reg)),
        "running sum smaller than the square leaving the window")
    `WETD_ASSERT(a_stall_hold, clk, rst_n,
        (s3_vld_reg && !en) |=> ($stable(s3_e_reg) && $stable(s3_ch_reg)),
        "last stage changed while the pipeline was stalled")

endmodule
